/* sv/v3m_pkg.sv */
// v3m_pkg: shared types, codes and helpers for the vec3 math unit
// used by every module of the block; depends on nothing

package v3m_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int NUM_REGS      = 6;
    localparam int SQRT_STAGES   = 32;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_SCALE = 4'd2;
    localparam logic [3:0] OP_NEG   = 4'd3;
    localparam logic [3:0] OP_DOT   = 4'd4;
    localparam logic [3:0] OP_CROSS = 4'd5;
    localparam logic [3:0] OP_MAG   = 4'd6;
    localparam logic [3:0] OP_NORM  = 4'd7;
    localparam logic [3:0] OP_POINT = 4'd8;
    localparam logic [3:0] OP_DIR   = 4'd9;
    localparam logic [3:0] OP_EQ    = 4'd10;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_NORM = 2'd1;
    localparam logic [1:0] ST_BAD_OP    = 2'd2;

    localparam logic [2:0] REG_ROW0_C01 = 3'd0;
    localparam logic [2:0] REG_ROW0_C23 = 3'd1;
    localparam logic [2:0] REG_ROW1_C01 = 3'd2;
    localparam logic [2:0] REG_ROW1_C23 = 3'd3;
    localparam logic [2:0] REG_ROW2_C01 = 3'd4;
    localparam logic [2:0] REG_ROW2_C23 = 3'd5;

    localparam logic [63:0] RST_ROW0_C01 = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_ROW0_C23 = 64'h0;
    localparam logic [63:0] RST_ROW1_C01 = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_ROW1_C23 = 64'h0;
    localparam logic [63:0] RST_ROW2_C01 = 64'h0;
    localparam logic [63:0] RST_ROW2_C23 = 64'h0000_0000_0001_0000;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] s;
    } item_t;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] res;
        logic signed [63:0] dot;
        logic [63:0]        sq;
        logic               eq;
    } lane_out_t;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] scalar;
        logic [2:0]         neg;
        logic [31:0]        abs_x;
        logic [31:0]        abs_y;
        logic [31:0]        abs_z;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

/* sv/v3m_lane.sv */
// v3m_lane: one component lane, operand select, multiply, round and sum
// depends on v3m_pkg

module v3m_lane #(
    parameter int FRAC_BITS = v3m_pkg::FRAC_BITS_DEF,
    parameter int LANE      = 0
) (
    input  logic                 clk,
    input  logic                 adv,
    input  v3m_pkg::item_t       item,
    input  logic signed [31:0]   m0,
    input  logic signed [31:0]   m1,
    input  logic signed [31:0]   m2,
    input  logic signed [31:0]   t,
    output v3m_pkg::lane_out_t   lane_out
);

    localparam int J  = (LANE + 1) % 3;
    localparam int K  = (LANE + 2) % 3;
    localparam int RW = 64 - FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [31:0] x0, y0, x1, y1, x2, y2;
    logic signed [32:0] ex_next;

    // stage 2: products
    logic [3:0]         op2_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [32:0] ex2_reg;
    logic signed [31:0] a2_reg;
    logic               eq2_reg;

    // stage 3: rounded products
    logic [3:0]         op3_reg;
    logic signed [RW-1:0] r0_reg, r1_reg, r2_reg;
    logic signed [32:0] ex3_reg;
    logic [63:0]        sq3_reg;
    logic signed [31:0] a3_reg;
    logic               eq3_reg;
    logic signed [63:0] rf0, rf1, rf2;

    // stage 4: lane result
    logic signed [65:0] acc_next;
    v3m_pkg::lane_out_t out_reg;

    assign av[0] = item.ax;
    assign av[1] = item.ay;
    assign av[2] = item.az;
    assign bv[0] = item.bx;
    assign bv[1] = item.by;
    assign bv[2] = item.bz;

    always_comb
    begin
        x0 = '0; y0 = '0; x1 = '0; y1 = '0; x2 = '0; y2 = '0;
        ex_next = '0;
        case (item.op) inside
            v3m_pkg::OP_ADD:   ex_next = 33'(av[LANE]) + 33'(bv[LANE]);
            v3m_pkg::OP_SUB:   ex_next = 33'(av[LANE]) - 33'(bv[LANE]);
            v3m_pkg::OP_NEG:   ex_next = -33'(av[LANE]);
            v3m_pkg::OP_SCALE:
            begin
                x0 = av[LANE]; y0 = item.s;
            end
            v3m_pkg::OP_DOT:
            begin
                x0 = av[LANE]; y0 = bv[LANE];
            end
            v3m_pkg::OP_CROSS:
            begin
                x0 = av[J]; y0 = bv[K];
                x1 = av[K]; y1 = bv[J];
            end
            v3m_pkg::OP_MAG, v3m_pkg::OP_NORM:
            begin
                x0 = av[LANE]; y0 = av[LANE];
            end
            v3m_pkg::OP_POINT, v3m_pkg::OP_DIR:
            begin
                x0 = m0; y0 = item.ax;
                x1 = m1; y1 = item.ay;
                x2 = m2; y2 = item.az;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op2_reg <= item.op;
            p0_reg  <= x0 * y0;
            p1_reg  <= x1 * y1;
            p2_reg  <= x2 * y2;
            ex2_reg <= ex_next;
            a2_reg  <= av[LANE];
            eq2_reg <= (av[LANE] == bv[LANE]);
        end
    end

    // round half up: add half an lsb, drop the fraction
    assign rf0 = p0_reg + HALF;
    assign rf1 = p1_reg + HALF;
    assign rf2 = p2_reg + HALF;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op3_reg <= op2_reg;
            r0_reg  <= rf0[63:FRAC_BITS];
            r1_reg  <= rf1[63:FRAC_BITS];
            r2_reg  <= rf2[63:FRAC_BITS];
            ex3_reg <= ex2_reg;
            sq3_reg <= p0_reg;
            a3_reg  <= a2_reg;
            eq3_reg <= eq2_reg;
        end
    end

    always_comb
    begin
        case (op3_reg) inside
            v3m_pkg::OP_ADD, v3m_pkg::OP_SUB, v3m_pkg::OP_NEG:
                acc_next = 66'(ex3_reg);
            v3m_pkg::OP_SCALE:
                acc_next = 66'(r0_reg);
            v3m_pkg::OP_CROSS:
                acc_next = 66'(r0_reg) - 66'(r1_reg);
            v3m_pkg::OP_POINT:
                acc_next = 66'(r0_reg) + 66'(r1_reg) + 66'(r2_reg) + 66'(t);
            v3m_pkg::OP_DIR:
                acc_next = 66'(r0_reg) + 66'(r1_reg) + 66'(r2_reg);
            default:
                acc_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.op  <= op3_reg;
            out_reg.a   <= a3_reg;
            out_reg.res <= v3m_pkg::sat32(acc_next);
            out_reg.dot <= 64'(r0_reg);
            out_reg.sq  <= sq3_reg;
            out_reg.eq  <= eq3_reg;
        end
    end

    assign lane_out = out_reg;

endmodule

/* sv/v3m_isqrt.sv */
// v3m_isqrt: pipelined integer square root, two radicand bits per stage
// depends on v3m_pkg

module v3m_isqrt (
    input  logic        clk,
    input  logic        adv,
    input  logic [63:0] sq,
    output logic [31:0] mag
);

    localparam int N = v3m_pkg::SQRT_STAGES;

    logic [63:0] n_reg    [N];
    logic [32:0] rem_reg  [N];
    logic [31:0] root_reg [N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic [63:0] n_in;
            logic [32:0] rem_in;
            logic [31:0] root_in;
            logic [34:0] rem_sh;
            logic [34:0] trial;
            logic [34:0] diff;
            logic        fit;

            if (g == 0)
            begin : g_first
                assign n_in    = sq;
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else
            begin : g_next
                assign n_in    = n_reg[g-1];
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
            end

            assign rem_sh = {rem_in, n_in[63:62]};
            assign trial  = {1'b0, root_in, 2'b01};
            assign fit    = (rem_sh >= trial);
            assign diff   = rem_sh - trial;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    n_reg[g]    <= {n_in[61:0], 2'b00};
                    rem_reg[g]  <= fit ? diff[32:0] : rem_sh[32:0];
                    root_reg[g] <= {root_in[30:0], fit};
                end
            end
        end
    endgenerate

    assign mag = root_reg[N-1];

endmodule

/* sv/v3m_div.sv */
// v3m_div: pipelined restoring divider, one quotient bit per stage
// depends on v3m_pkg for the default fraction width

module v3m_div #(
    parameter int FRAC_BITS = v3m_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               adv,
    input  logic [31:0]        num,
    input  logic [31:0]        dvs,
    output logic [FRAC_BITS:0] quo,
    output logic [31:0]        dvs_out
);

    localparam int N = FRAC_BITS + 1;

    logic [31:0]        rem_reg [N];
    logic [31:0]        dvs_reg [N];
    logic [FRAC_BITS:0] quo_reg [N];

    // num never exceeds dvs, so the quotient fits FRAC_BITS+1 bits
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic [32:0]        r_in;
            logic [31:0]        d_in;
            logic [FRAC_BITS:0] q_in;
            logic [32:0]        diff;
            logic               fit;

            if (g == 0)
            begin : g_first
                assign r_in = {1'b0, num};
                assign d_in = dvs;
                assign q_in = '0;
            end
            else
            begin : g_next
                assign r_in = {rem_reg[g-1], 1'b0};
                assign d_in = dvs_reg[g-1];
                assign q_in = quo_reg[g-1];
            end

            assign fit  = (r_in >= {1'b0, d_in});
            assign diff = r_in - {1'b0, d_in};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[g] <= fit ? diff[31:0] : r_in[31:0];
                    dvs_reg[g] <= d_in;
                    quo_reg[g] <= {q_in[FRAC_BITS-1:0], fit};
                end
            end
        end
    endgenerate

    assign quo     = quo_reg[N-1];
    assign dvs_out = dvs_reg[N-1];

endmodule

/* sv/vec3_math_unit.sv */
// vec3_math_unit: top level, matrix registers, lanes, root and divide pipes, merge
// depends on v3m_pkg, v3m_lane, v3m_isqrt, v3m_div

// Takes one item per clock and gives one result per clock for every opcode
// while the output is not stalled. Every item passes the depth of the 32-stage
// square root pipeline and the FRAC_BITS+1 stage divider used for normalize;
// all other opcodes ride along in a matching delay line. The whole pipeline
// advances when the output register is empty or taken, so in_ready follows
// out_ready. The user must write the matrix through the cfg port only while
// no item is in flight; the block itself does not enforce this.

module vec3_math_unit #(
    parameter int FRAC_BITS = v3m_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         opcode,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scale_factor,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic signed [31:0] scalar_out,
    output logic [1:0]         status,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    localparam int SB_N = v3m_pkg::SQRT_STAGES + FRAC_BITS + 1;
    localparam int NV   = 5 + SB_N;

    logic adv;
    logic [63:0] cfg_reg [v3m_pkg::NUM_REGS];
    logic [NV-1:0] vld_reg;

    v3m_pkg::item_t     item_reg;
    v3m_pkg::lane_out_t lo [3];

    v3m_pkg::side_t side5_reg;
    v3m_pkg::side_t side_next;
    logic [63:0]    sq5_reg;
    v3m_pkg::side_t sb_reg [SB_N];

    logic [31:0]        mag;
    logic [31:0]        mag_end [3];
    logic [FRAC_BITS:0] quo [3];

    logic signed [31:0] rx_next, ry_next, rz_next, sc_next;
    logic [1:0]         st_next;
    logic signed [31:0] qx, qy, qz;
    logic               out_valid_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[v3m_pkg::REG_ROW0_C01] <= v3m_pkg::RST_ROW0_C01;
            cfg_reg[v3m_pkg::REG_ROW0_C23] <= v3m_pkg::RST_ROW0_C23;
            cfg_reg[v3m_pkg::REG_ROW1_C01] <= v3m_pkg::RST_ROW1_C01;
            cfg_reg[v3m_pkg::REG_ROW1_C23] <= v3m_pkg::RST_ROW1_C23;
            cfg_reg[v3m_pkg::REG_ROW2_C01] <= v3m_pkg::RST_ROW2_C01;
            cfg_reg[v3m_pkg::REG_ROW2_C23] <= v3m_pkg::RST_ROW2_C23;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                v3m_pkg::REG_ROW0_C01: cfg_reg[v3m_pkg::REG_ROW0_C01] <= cfg_data;
                v3m_pkg::REG_ROW0_C23: cfg_reg[v3m_pkg::REG_ROW0_C23] <= cfg_data;
                v3m_pkg::REG_ROW1_C01: cfg_reg[v3m_pkg::REG_ROW1_C01] <= cfg_data;
                v3m_pkg::REG_ROW1_C23: cfg_reg[v3m_pkg::REG_ROW1_C23] <= cfg_data;
                v3m_pkg::REG_ROW2_C01: cfg_reg[v3m_pkg::REG_ROW2_C01] <= cfg_data;
                v3m_pkg::REG_ROW2_C23: cfg_reg[v3m_pkg::REG_ROW2_C23] <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits for every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NV-2:0], in_valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg.op <= opcode;
            item_reg.ax <= a_x;
            item_reg.ay <= a_y;
            item_reg.az <= a_z;
            item_reg.bx <= b_x;
            item_reg.by <= b_y;
            item_reg.bz <= b_z;
            item_reg.s  <= scale_factor;
        end
    end

    genvar l;
    generate
        for (l = 0; l < 3; l++)
        begin : g_lane
            v3m_lane #(
                .FRAC_BITS (FRAC_BITS),
                .LANE      (l)
            ) u_lane (
                .clk      (clk),
                .adv      (adv),
                .item     (item_reg),
                .m0       (cfg_reg[2*l][31:0]),
                .m1       (cfg_reg[2*l][63:32]),
                .m2       (cfg_reg[2*l+1][31:0]),
                .t        (cfg_reg[2*l+1][63:32]),
                .lane_out (lo[l])
            );
        end
    endgenerate

    // merge lanes: dot sum, equality, squared length, magnitudes of A
    always_comb
    begin
        side_next.op  = lo[0].op;
        side_next.rx  = lo[0].res;
        side_next.ry  = lo[1].res;
        side_next.rz  = lo[2].res;
        side_next.neg = {lo[2].a[31], lo[1].a[31], lo[0].a[31]};
        side_next.abs_x = lo[0].a[31] ? (~lo[0].a + 32'd1) : lo[0].a;
        side_next.abs_y = lo[1].a[31] ? (~lo[1].a + 32'd1) : lo[1].a;
        side_next.abs_z = lo[2].a[31] ? (~lo[2].a + 32'd1) : lo[2].a;
        case (lo[0].op)
            v3m_pkg::OP_DOT:
                side_next.scalar = v3m_pkg::sat32(66'(lo[0].dot) + 66'(lo[1].dot)
                                                  + 66'(lo[2].dot));
            v3m_pkg::OP_EQ:
                side_next.scalar = (lo[0].eq && lo[1].eq && lo[2].eq) ? 32'sd1 : 32'sd0;
            default:
                side_next.scalar = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side5_reg <= side_next;
            sq5_reg   <= lo[0].sq + lo[1].sq + lo[2].sq;
        end
    end

    // sideband delay matching the root and divide pipes
    genvar k;
    generate
        for (k = 0; k < SB_N; k++)
        begin : g_sb
            always_ff @(posedge clk)
            begin
                if (adv)
                    sb_reg[k] <= (k == 0) ? side5_reg : sb_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    v3m_isqrt u_isqrt (
        .clk (clk),
        .adv (adv),
        .sq  (sq5_reg),
        .mag (mag)
    );

    v3m_div #(.FRAC_BITS (FRAC_BITS)) u_div_x (
        .clk     (clk),
        .adv     (adv),
        .num     (sb_reg[v3m_pkg::SQRT_STAGES-1].abs_x),
        .dvs     (mag),
        .quo     (quo[0]),
        .dvs_out (mag_end[0])
    );

    v3m_div #(.FRAC_BITS (FRAC_BITS)) u_div_y (
        .clk     (clk),
        .adv     (adv),
        .num     (sb_reg[v3m_pkg::SQRT_STAGES-1].abs_y),
        .dvs     (mag),
        .quo     (quo[1]),
        .dvs_out (mag_end[1])
    );

    v3m_div #(.FRAC_BITS (FRAC_BITS)) u_div_z (
        .clk     (clk),
        .adv     (adv),
        .num     (sb_reg[v3m_pkg::SQRT_STAGES-1].abs_z),
        .dvs     (mag),
        .quo     (quo[2]),
        .dvs_out (mag_end[2])
    );

    assign qx = sb_reg[SB_N-1].neg[0] ? -32'(quo[0]) : 32'(quo[0]);
    assign qy = sb_reg[SB_N-1].neg[1] ? -32'(quo[1]) : 32'(quo[1]);
    assign qz = sb_reg[SB_N-1].neg[2] ? -32'(quo[2]) : 32'(quo[2]);

    // final result select
    always_comb
    begin
        rx_next = sb_reg[SB_N-1].rx;
        ry_next = sb_reg[SB_N-1].ry;
        rz_next = sb_reg[SB_N-1].rz;
        sc_next = sb_reg[SB_N-1].scalar;
        st_next = v3m_pkg::ST_OK;
        case (sb_reg[SB_N-1].op) inside
            v3m_pkg::OP_MAG:
                sc_next = mag_end[0][31] ? 32'sh7fff_ffff : mag_end[0];
            v3m_pkg::OP_NORM:
            begin
                // zero vector: A is all zero, hand it back and flag it
                if (mag_end[0] == '0)
                begin
                    rx_next = '0;
                    ry_next = '0;
                    rz_next = '0;
                    st_next = v3m_pkg::ST_ZERO_NORM;
                end
                else
                begin
                    rx_next = qx;
                    ry_next = qy;
                    rz_next = qz;
                end
            end
            v3m_pkg::OP_ADD, v3m_pkg::OP_SUB, v3m_pkg::OP_SCALE, v3m_pkg::OP_NEG,
            v3m_pkg::OP_DOT, v3m_pkg::OP_CROSS, v3m_pkg::OP_POINT, v3m_pkg::OP_DIR,
            v3m_pkg::OP_EQ: ;
            default:
            begin
                rx_next = '0;
                ry_next = '0;
                rz_next = '0;
                sc_next = '0;
                st_next = v3m_pkg::ST_BAD_OP;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_x        <= rx_next;
            r_y        <= ry_next;
            r_z        <= rz_next;
            scalar_out <= sc_next;
            status     <= st_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* sv/v3m_checker.sv */
// v3m_checker: port-level assertions for the vec3 math unit, bound to the top
// depends on v3m_pkg and vec3_math_unit

module v3m_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] r_x,
    input logic signed [31:0] r_y,
    input logic signed [31:0] r_z,
    input logic signed [31:0] scalar_out,
    input logic [1:0]         status
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(r_x) && $stable(r_y)
                                   && $stable(r_z) && $stable(scalar_out))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("status code out of range");

    a_bad_op_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == v3m_pkg::ST_BAD_OP |->
            r_x == 0 && r_y == 0 && r_z == 0 && scalar_out == 0)
        else $error("unknown opcode item gave non-zero fields");

    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == v3m_pkg::ST_ZERO_NORM |->
            r_x == 0 && r_y == 0 && r_z == 0 && scalar_out == 0)
        else $error("zero vector normalize gave non-zero fields");

endmodule

bind vec3_math_unit v3m_checker u_v3m_checker (.*);

/* tb/tb_top.sv */
// tb_top: self-checking bench for vec3_math_unit, random and directed items with
// a vector-maths predictor and an in-order scoreboard; depends on v3m_pkg and the rtl

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] sc;
        logic [1:0]         st;
    } vres_t;

    class vec3_scoreboard;
        vres_t pending[$];
        int    errors;
        logic [63:0] mtx[v3m_pkg::NUM_REGS];

        function new();
            errors = 0;
            mtx[v3m_pkg::REG_ROW0_C01] = v3m_pkg::RST_ROW0_C01;
            mtx[v3m_pkg::REG_ROW0_C23] = v3m_pkg::RST_ROW0_C23;
            mtx[v3m_pkg::REG_ROW1_C01] = v3m_pkg::RST_ROW1_C01;
            mtx[v3m_pkg::REG_ROW1_C23] = v3m_pkg::RST_ROW1_C23;
            mtx[v3m_pkg::REG_ROW2_C01] = v3m_pkg::RST_ROW2_C01;
            mtx[v3m_pkg::REG_ROW2_C23] = v3m_pkg::RST_ROW2_C23;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            if (idx < v3m_pkg::NUM_REGS)
                mtx[idx] = v;
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint rmul(longint a, longint b);
            longint p;
            p = a * b + (64'sd1 <<< (v3m_pkg::FRAC_BITS_DEF - 1));
            return p >>> v3m_pkg::FRAC_BITS_DEF;
        endfunction

        function longint melem(int row, int col);
            logic [63:0] r;
            r = mtx[row * 2 + col / 2];
            return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function void note_item(v3m_pkg::item_t it);
            vres_t e;
            longint a[3], b[3], r[3], s, acc;
            longint unsigned sq, mag;
            a[0] = longint'(it.ax); a[1] = longint'(it.ay); a[2] = longint'(it.az);
            b[0] = longint'(it.bx); b[1] = longint'(it.by); b[2] = longint'(it.bz);
            s = longint'(it.s);
            r = '{0, 0, 0};
            e.sc = 0;
            e.st = v3m_pkg::ST_OK;
            case (it.op) inside
                v3m_pkg::OP_ADD:
                    for (int i = 0; i < 3; i++) r[i] = clip(a[i] + b[i]);
                v3m_pkg::OP_SUB:
                    for (int i = 0; i < 3; i++) r[i] = clip(a[i] - b[i]);
                v3m_pkg::OP_SCALE:
                    for (int i = 0; i < 3; i++) r[i] = clip(rmul(a[i], s));
                v3m_pkg::OP_NEG:
                    for (int i = 0; i < 3; i++) r[i] = clip(-a[i]);
                v3m_pkg::OP_DOT:
                    e.sc = 32'(clip(rmul(a[0], b[0]) + rmul(a[1], b[1])
                                    + rmul(a[2], b[2])));
                v3m_pkg::OP_CROSS:
                begin
                    r[0] = clip(rmul(a[1], b[2]) - rmul(a[2], b[1]));
                    r[1] = clip(rmul(a[2], b[0]) - rmul(a[0], b[2]));
                    r[2] = clip(rmul(a[0], b[1]) - rmul(a[1], b[0]));
                end
                v3m_pkg::OP_MAG, v3m_pkg::OP_NORM:
                begin
                    sq = 0;
                    for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
                    mag = root(sq);
                    if (it.op == v3m_pkg::OP_MAG)
                        e.sc = (mag > 64'd2147483647) ? 32'sh7fff_ffff : mag[31:0];
                    else if (mag == 0)
                        e.st = v3m_pkg::ST_ZERO_NORM;
                    else
                        for (int i = 0; i < 3; i++)
                            r[i] = clip((a[i] * (64'sd1 <<< v3m_pkg::FRAC_BITS_DEF))
                                        / longint'(mag));
                end
                v3m_pkg::OP_POINT, v3m_pkg::OP_DIR:
                    for (int i = 0; i < 3; i++)
                    begin
                        acc = rmul(melem(i, 0), a[0]) + rmul(melem(i, 1), a[1])
                            + rmul(melem(i, 2), a[2]);
                        if (it.op == v3m_pkg::OP_POINT)
                            acc += melem(i, 3);
                        r[i] = clip(acc);
                    end
                v3m_pkg::OP_EQ:
                    e.sc = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2]) ? 32'sd1 : 32'sd0;
                default:
                    e.st = v3m_pkg::ST_BAD_OP;
            endcase
            e.rx = r[0][31:0];
            e.ry = r[1][31:0];
            e.rz = r[2][31:0];
            pending.push_back(e);
        endfunction

        function void check_result(vres_t got);
            vres_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result r=%h %h %h sc=%h st=%0d", $realtime,
                         got.rx, got.ry, got.rz, got.sc, got.st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.rx !== e.rx)
                begin $display("%0t: r_x exp %h got %h", $realtime, e.rx, got.rx); errors++; end
            if (got.ry !== e.ry)
                begin $display("%0t: r_y exp %h got %h", $realtime, e.ry, got.ry); errors++; end
            if (got.rz !== e.rz)
                begin $display("%0t: r_z exp %h got %h", $realtime, e.rz, got.rz); errors++; end
            if (got.sc !== e.sc)
                begin
                    $display("%0t: scalar_out exp %h got %h", $realtime, e.sc, got.sc);
                    errors++;
                end
            if (got.st !== e.st)
                begin
                    $display("%0t: status exp %0d got %0d", $realtime, e.st, got.st);
                    errors++;
                end
        endfunction
    endclass

    localparam int LATENCY    = 5 + v3m_pkg::SQRT_STAGES + v3m_pkg::FRAC_BITS_DEF + 1 + 1;
    localparam int STALL_MAX  = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
    logic in_ready, out_valid, cfg_ready;
    logic [3:0] opcode = '0;
    logic signed [31:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
    logic signed [31:0] scale_factor = '0;
    logic signed [31:0] r_x, r_y, r_z, scalar_out;
    logic [1:0] status;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    vec3_scoreboard vsb = new();
    int idle_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    vec3_math_unit u_top (.*);

    // result side: sample at the rising edge, stall pattern changes on the falling edge
    always @(posedge clk)
    begin
        vres_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.rx = r_x; got.ry = r_y; got.rz = r_z; got.sc = scalar_out; got.st = status;
            vsb.check_result(got);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    int stall_mode = 0;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
        if (idle_cycles > STALL_MAX)
        begin
            $display("tb_top NOT OK");
            $finish;
        end

    task automatic send_item(v3m_pkg::item_t it);
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= it.op;
        a_x <= it.ax; a_y <= it.ay; a_z <= it.az;
        b_x <= it.bx; b_y <= it.by; b_z <= it.bz;
        scale_factor <= it.s;
        do
            @(posedge clk);
        while (!in_ready);
        vsb.note_item(it);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        vsb.set_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (vsb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
            2: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            3: return 32'sh7fff_ffff - $urandom_range(0, 3);
            4: return 32'sh8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h0fff)) - 32'sh0800;
        endcase
    endfunction

    function automatic v3m_pkg::item_t rand_item();
        v3m_pkg::item_t it;
        it.op = ($urandom_range(0, 19) == 0)
                ? 4'($urandom_range(11, 15))
                : 4'($urandom_range(v3m_pkg::OP_ADD, v3m_pkg::OP_EQ));
        it.ax = rand_val(); it.ay = rand_val(); it.az = rand_val();
        it.bx = rand_val(); it.by = rand_val(); it.bz = rand_val();
        it.s = rand_val();
        if (it.op == v3m_pkg::OP_EQ && $urandom_range(0, 1))
        begin
            it.bx = it.ax; it.by = it.ay;
            if ($urandom_range(0, 1))
                it.bz = it.az;
        end
        if (it.op == v3m_pkg::OP_NORM && $urandom_range(0, 7) == 0)
            begin it.ax = 0; it.ay = 0; it.az = 0; end
        return it;
    endfunction

    function automatic logic [63:0] rand_reg();
        case ($urandom_range(0, 2))
            0: return {$urandom, $urandom};
            1: return {32'($signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000),
                       32'($signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000)};
            default: return {32'sh7fff_ffff, 32'sh8000_0000};
        endcase
    endfunction

    task automatic random_burst(int n);
        int sent, len;
        sent = 0;
        while (sent < n)
        begin
            len = $urandom_range(1, 30);
            for (int k = 0; k < len && sent < n; k++, sent++)
                send_item(rand_item());
            if ($urandom_range(0, 3) != 0)
            begin
                drop_valid();
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
        end
        drop_valid();
    endtask

    initial
    begin
        v3m_pkg::item_t it;
        logic signed [31:0] mx, mn;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every opcode, the extremes, zero normalize and bad opcodes
        for (int op = 0; op < 16; op++)
        begin
            it = '{op: 4'(op), ax: mx, ay: mn, az: 32'sh0001_0000,
                   bx: mx, by: mn, bz: -32'sh0001_0000, s: mx};
            send_item(it);
        end
        send_item('{v3m_pkg::OP_NORM, 0, 0, 0, 1, 2, 3, 4});
        send_item('{v3m_pkg::OP_NEG, mn, mn, mn, 0, 0, 0, 0});
        send_item('{v3m_pkg::OP_SCALE, mn, mx, -1, 0, 0, 0, mn});
        send_item('{v3m_pkg::OP_EQ, 5, -5, mn, 5, -5, mn, 0});
        send_item('{v3m_pkg::OP_MAG, mn, mn, mn, 0, 0, 0, 0});
        send_item('{v3m_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0});
        send_item('{v3m_pkg::OP_POINT, mx, mn, mx, 0, 0, 0, 0});
        send_item('{v3m_pkg::OP_DOT, mn, mn, mn, mn, mn, mn, 0});
        drop_valid();

        // matrix phases: extremes first, then random settings
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            for (int r = 0; r < v3m_pkg::NUM_REGS; r++)
                case (ph)
                    0: write_reg(3'(r), 64'hffff_ffff_ffff_ffff);
                    1: write_reg(3'(r), {mx, mn});
                    2: write_reg(3'(r), 64'h0);
                    default: write_reg(3'(r), rand_reg());
                endcase
            if (ph == 3)
            begin
                send_item('{v3m_pkg::OP_POINT, mx, mx, mx, 0, 0, 0, 0});
                send_item('{v3m_pkg::OP_DIR, mn, mn, mn, 0, 0, 0, 0});
            end
            random_burst(105);
        end
        drain();

        if (vsb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

/* files.f */
sv/v3m_pkg.sv
sv/v3m_lane.sv
sv/v3m_isqrt.sv
sv/v3m_div.sv
sv/vec3_math_unit.sv
sv/v3m_checker.sv
tb/tb_top.sv
